@@ rtl/ssi_pkg.sv @@
package ssi_pkg;

    localparam int SAMPLE_W = 32;
    localparam int EVENT_W  = 2;
    localparam int LEN_W    = 6;
    localparam int CNT_W    = 32;
    // history ring: 64 entries, pointer wraps on its own
    localparam int HIST_AW  = 6;
    localparam int HIST_DEPTH = 1 << HIST_AW;

    localparam int MAX_SLIP_LEN_DEF = 63;

    localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DUP  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DEL  = 2'd2;

    // one emitting item: history replay length, then the sample itself
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [LEN_W-1:0]    rep_len;
        logic [CNT_W-1:0]    applied;
        logic [CNT_W-1:0]    dropped;
    } cmd_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

@@ rtl/sample_slip_injector.sv @@
// Channel | Dir | Bus fields (low bit up)                         | Beat
// s_*     | in  | tdata: sample[31:0], slip_length[37:32], pad     | one raw sample
//         |     | tuser: slip_event[1:0]                            |
// m_*     | out | tdata: out_sample[31:0], applied_total[63:32],    | one emitted sample
//         |     |        dropped_total[95:64]; tlast: last          |
//
// Beats: a plain or failed-duplicate beat emits one beat; a duplicate of
//   length L emits L+1 beats: one history read runs ahead of the first
//   replayed beat, then one beat per cycle unless m_tready holds the output
//   register, set by the single read port of the back-end history ring.
// Deleted beats produce nothing.
// Reset: rst_n async, clears counters, pointers and handshake state; the
//   history ring is not cleared (reads are gated by the fill count).
// Stalls: a two-entry command queue splits front from back; s_tready drops
//   only when that queue is full, and m_tready low holds the output register.
module sample_slip_injector
#(
    parameter int MAX_SLIP_LEN = ssi_pkg::MAX_SLIP_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sample[31:0], slip_length[37:32], zero pad
    input  logic [1:0]  s_tuser,   // slip_event[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // out_sample, applied_total, dropped_total
    output logic        m_tlast    // last beat caused by this input beat
);

    logic          fq_valid;
    logic          fq_ready;
    ssi_pkg::cmd_t fq_cmd;
    logic          qb_valid;
    logic          qb_ready;
    ssi_pkg::cmd_t qb_cmd;

    logic [ssi_pkg::SAMPLE_W-1:0] out_sample;
    logic [ssi_pkg::CNT_W-1:0]    applied_total;
    logic [ssi_pkg::CNT_W-1:0]    dropped_total;

    // front: classify beat, keep delete run, fill count and counters
    ssi_front #(
        .MAX_SLIP_LEN (MAX_SLIP_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .sample      (s_tdata[31:0]),
        .slip_event  (s_tuser),
        .slip_length (s_tdata[37:32]),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_cmd       (fq_cmd)
    );

    ssi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // back: replay from history ring, then emit the sample itself
    ssi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_cmd         (qb_cmd),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_sample    (out_sample),
        .out_last      (m_tlast),
        .applied_total (applied_total),
        .dropped_total (dropped_total)
    );

    assign m_tdata = {dropped_total, applied_total, out_sample};

endmodule

@@ rtl/ssi_queue.sv @@
module ssi_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ssi_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output ssi_pkg::cmd_t out_cmd
);

    ssi_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ rtl/ssi_front.sv @@
module ssi_front
#(
    parameter int MAX_SLIP_LEN = ssi_pkg::MAX_SLIP_LEN_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ssi_pkg::SAMPLE_W-1:0] sample,
    input  logic [ssi_pkg::EVENT_W-1:0]  slip_event,
    input  logic [ssi_pkg::LEN_W-1:0]    slip_length,
    output logic                         q_valid,
    input  logic                         q_ready,
    output ssi_pkg::cmd_t                q_cmd
);

    localparam logic [ssi_pkg::LEN_W-1:0] MAX_L = ssi_pkg::LEN_W'(MAX_SLIP_LEN);

    logic [ssi_pkg::LEN_W-1:0]   del_left_reg, del_left_next;
    logic [ssi_pkg::LEN_W-1:0]   fill_reg, fill_next;
    logic [ssi_pkg::CNT_W-1:0]   applied_reg, applied_next;
    logic [ssi_pkg::CNT_W-1:0]   dropped_reg, dropped_next;
    logic [ssi_pkg::LEN_W-1:0]   len_sat;
    logic [ssi_pkg::EVENT_W-1:0] ev;
    logic [ssi_pkg::LEN_W-1:0]   rep_len;
    logic                        emits;
    logic                        accept;
    logic [ssi_pkg::LEN_W:0]     fill_sum;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;
    assign len_sat  = (slip_length > MAX_L) ? MAX_L : slip_length;

    always_comb
    begin
        ev = slip_event;
        if (slip_event != ssi_pkg::EV_DUP && slip_event != ssi_pkg::EV_DEL)
        begin
            ev = ssi_pkg::EV_NONE;
        end
        if (len_sat == '0)
        begin
            ev = ssi_pkg::EV_NONE;
        end
    end

    always_comb
    begin
        del_left_next = del_left_reg;
        applied_next  = applied_reg;
        dropped_next  = dropped_reg;
        rep_len       = '0;
        emits         = 1'b0;
        if (del_left_reg != '0)
        begin
            del_left_next = del_left_reg - ssi_pkg::LEN_W'(1);
            if (ev != ssi_pkg::EV_NONE)
            begin
                dropped_next = ssi_pkg::sat_inc(dropped_reg);
            end
        end
        else if (ev == ssi_pkg::EV_DEL)
        begin
            del_left_next = len_sat - ssi_pkg::LEN_W'(1);
            applied_next  = ssi_pkg::sat_inc(applied_reg);
        end
        else
        begin
            emits = 1'b1;
            if (ev == ssi_pkg::EV_DUP)
            begin
                if (fill_reg < len_sat)
                begin
                    dropped_next = ssi_pkg::sat_inc(dropped_reg);
                end
                else
                begin
                    rep_len      = len_sat;
                    applied_next = ssi_pkg::sat_inc(applied_reg);
                end
            end
        end
    end

    // history grows by the replay plus the sample, capped at the max length
    assign fill_sum  = {1'b0, fill_reg} + {1'b0, rep_len} + (ssi_pkg::LEN_W+1)'(1);
    assign fill_next = (fill_sum > {1'b0, MAX_L}) ? MAX_L : fill_sum[ssi_pkg::LEN_W-1:0];

    assign q_valid       = accept && emits;
    assign q_cmd.sample  = sample;
    assign q_cmd.rep_len = rep_len;
    assign q_cmd.applied = applied_next;
    assign q_cmd.dropped = dropped_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            del_left_reg <= '0;
            fill_reg     <= '0;
            applied_reg  <= '0;
            dropped_reg  <= '0;
        end
        else if (accept)
        begin
            del_left_reg <= del_left_next;
            applied_reg  <= applied_next;
            dropped_reg  <= dropped_next;
            if (emits)
            begin
                fill_reg <= fill_next;
            end
        end
    end

endmodule

@@ rtl/ssi_back.sv @@
module ssi_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  ssi_pkg::cmd_t                q_cmd,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ssi_pkg::SAMPLE_W-1:0] out_sample,
    output logic                         out_last,
    output logic [ssi_pkg::CNT_W-1:0]    applied_total,
    output logic [ssi_pkg::CNT_W-1:0]    dropped_total
);

    logic [ssi_pkg::SAMPLE_W-1:0] hist_mem [ssi_pkg::HIST_DEPTH];

    logic                         act_reg, act_next;
    ssi_pkg::cmd_t                cur_reg;
    logic [ssi_pkg::LEN_W-1:0]    cnt_reg, cnt_next;
    logic                         pend_reg, pend_next;
    logic [ssi_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [ssi_pkg::HIST_AW-1:0]  wp_reg, wp_next;
    logic [ssi_pkg::HIST_AW-1:0]  rbase_reg;
    logic [ssi_pkg::HIST_AW-1:0]  raddr;
    logic                         ovalid_reg;
    logic [ssi_pkg::SAMPLE_W-1:0] osample_reg;
    logic                         olast_reg;
    logic [ssi_pkg::CNT_W-1:0]    oapplied_reg;
    logic [ssi_pkg::CNT_W-1:0]    odropped_reg;

    logic                         adv;
    logic                         emit_hist;
    logic                         emit_fin;
    logic                         emit;
    logic                         issue;
    logic                         load;
    logic [ssi_pkg::SAMPLE_W-1:0] wdata;

    assign adv       = !ovalid_reg || out_ready;
    assign emit_hist = pend_reg && adv;
    assign emit_fin  = act_reg && !pend_reg && (cnt_reg == cur_reg.rep_len) && adv;
    assign emit      = emit_hist || emit_fin;
    assign wdata     = emit_hist ? rd_data_reg : cur_reg.sample;
    assign q_ready   = !act_reg || emit_fin;
    assign load      = q_valid && q_ready;
    assign issue     = act_reg && (cnt_reg != cur_reg.rep_len) && (!pend_reg || emit_hist);
    assign raddr     = rbase_reg + cnt_reg;
    assign wp_next   = emit ? wp_reg + ssi_pkg::HIST_AW'(1) : wp_reg;

    always_comb
    begin
        act_next = act_reg;
        if (load)
        begin
            act_next = 1'b1;
        end
        else if (emit_fin)
        begin
            act_next = 1'b0;
        end
        cnt_next = load ? '0 : (issue ? cnt_reg + ssi_pkg::LEN_W'(1) : cnt_reg);
        pend_next = issue ? 1'b1 : (emit_hist ? 1'b0 : pend_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= 1'b0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            wp_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            act_reg  <= act_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            wp_reg   <= wp_next;
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg   <= q_cmd;
            // replay starts rep_len entries behind the write pointer
            rbase_reg <= wp_next - q_cmd.rep_len;
        end
        if (emit)
        begin
            osample_reg  <= wdata;
            olast_reg    <= emit_fin;
            oapplied_reg <= cur_reg.applied;
            odropped_reg <= cur_reg.dropped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            hist_mem[wp_reg] <= wdata;
        end
        if (issue)
        begin
            rd_data_reg <= hist_mem[raddr];
        end
    end

    assign out_valid     = ovalid_reg;
    assign out_sample    = osample_reg;
    assign out_last      = olast_reg;
    assign applied_total = oapplied_reg;
    assign dropped_total = odropped_reg;

`ifndef ASSERT_OFF
    a_pend_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> act_reg)
        else $error("history read pending with no active item");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> (cnt_reg <= cur_reg.rep_len))
        else $error("replay read count past replay length");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && emit) |-> (raddr != wp_reg))
        else $error("history read and write hit the same entry");

    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (wp_reg == $past(wp_reg) + ssi_pkg::HIST_AW'(1)))
        else $error("write pointer did not advance on emitted beat");
`endif

endmodule

@@ tb/sample_slip_injector_checker.sv @@
module sample_slip_injector_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // sample[31:0], slip_length[37:32], zero pad
    input  logic [1:0]  s_tuser,   // slip_event[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,   // out_sample, applied_total, dropped_total
    input  logic        m_tlast,
    output int          errors,
    output int          pending,
    output int          checked
);

    localparam int MAX_LEN = ssi_pkg::MAX_SLIP_LEN_DEF;
    localparam logic [ssi_pkg::LEN_W-1:0] MAX_L = ssi_pkg::LEN_W'(MAX_LEN);

    typedef struct packed {
        logic [ssi_pkg::SAMPLE_W-1:0] smp;
        logic                         last;
        logic [ssi_pkg::CNT_W-1:0]    applied;
        logic [ssi_pkg::CNT_W-1:0]    dropped;
    } emit_t;

    emit_t expected_emits[$];

    // emitted samples, entry 0 newest
    logic [ssi_pkg::SAMPLE_W-1:0] history [0:MAX_LEN-1];
    logic [ssi_pkg::LEN_W-1:0]    hist_fill = '0;
    logic [ssi_pkg::LEN_W-1:0]    del_left = '0;
    logic [ssi_pkg::CNT_W-1:0]    applied_cnt = '0;
    logic [ssi_pkg::CNT_W-1:0]    dropped_cnt = '0;

    int err_cnt = 0;
    int exp_cnt = 0;
    int ok_cnt = 0;

    assign errors  = err_cnt;
    assign pending = exp_cnt;
    assign checked = ok_cnt;

    task automatic count_applied();
        if (applied_cnt != '1)
            applied_cnt = applied_cnt + ssi_pkg::CNT_W'(1);
    endtask

    task automatic count_dropped();
        if (dropped_cnt != '1)
            dropped_cnt = dropped_cnt + ssi_pkg::CNT_W'(1);
    endtask

    task automatic predict_emits(input logic [ssi_pkg::SAMPLE_W-1:0] smp,
                                 input logic [ssi_pkg::EVENT_W-1:0]  ev_raw,
                                 input logic [ssi_pkg::LEN_W-1:0]    len_raw);
        logic [ssi_pkg::SAMPLE_W-1:0] seq [$];
        logic [ssi_pkg::LEN_W-1:0]    len;
        logic [ssi_pkg::EVENT_W-1:0]  ev;
        emit_t                        e;
        len = (len_raw > MAX_L) ? MAX_L : len_raw;
        ev  = ev_raw;
        // spare code and zero length both mean no event
        if ((ev != ssi_pkg::EV_DUP && ev != ssi_pkg::EV_DEL) || len == '0)
            ev = ssi_pkg::EV_NONE;

        if (del_left != '0) begin
            del_left = del_left - ssi_pkg::LEN_W'(1);
            if (ev != ssi_pkg::EV_NONE)
                count_dropped();
        end else if (ev == ssi_pkg::EV_DEL) begin
            del_left = len - ssi_pkg::LEN_W'(1);
            count_applied();
        end else begin
            if (ev == ssi_pkg::EV_DUP) begin
                if (hist_fill < len) begin
                    count_dropped();
                end else begin
                    for (int i = int'(len); i > 0; i--)
                        seq.push_back(history[i-1]);
                    count_applied();
                end
            end
            seq.push_back(smp);
            for (int k = 0; k < seq.size(); k++) begin
                for (int j = MAX_LEN - 1; j > 0; j--)
                    history[j] = history[j-1];
                history[0] = seq[k];
                if (hist_fill < MAX_L)
                    hist_fill = hist_fill + ssi_pkg::LEN_W'(1);
                e.smp     = seq[k];
                e.last    = (k == seq.size() - 1);
                e.applied = applied_cnt;
                e.dropped = dropped_cnt;
                expected_emits.push_back(e);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        emit_t want;
        if (!rst_n) begin
            hist_fill   = '0;
            del_left    = '0;
            applied_cnt = '0;
            dropped_cnt = '0;
            expected_emits.delete();
            exp_cnt     = 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_emits(s_tdata[31:0], s_tuser, s_tdata[37:32]);
            if (m_tvalid && m_tready) begin
                if (expected_emits.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected output beat: expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = expected_emits.pop_front();
                    check_field("out_sample", want.smp, m_tdata[31:0]);
                    check_field("last", {31'd0, want.last}, {31'd0, m_tlast});
                    check_field("applied_total", want.applied, m_tdata[63:32]);
                    check_field("dropped_total", want.dropped, m_tdata[95:64]);
                    ok_cnt++;
                end
            end
            exp_cnt = expected_emits.size();
        end
    end

endmodule

@@ tb/tb_sample_slip_injector.sv @@
module tb_sample_slip_injector;

    // spare event code, must behave as no event
    localparam logic [ssi_pkg::EVENT_W-1:0] EV_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 60;     // long output stall, fills the command queue
    localparam int STALL_LIMIT = 2000;   // watchdog: cycles without any accepted beat

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // sample[31:0], slip_length[37:32], zero pad
    logic [1:0]  s_tuser;    // slip_event[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;    // out_sample[31:0], applied_total[63:32], dropped_total[95:64]
    logic        m_tlast;    // last beat caused by one input beat

    int errors;
    int pending;
    int checked;

    // stimulus knobs; rx_jitter and hold_req are shared with the receiver process
    bit tx_jitter = 1'b1;
    bit rx_jitter = 1'b1;
    bit hold_req  = 1'b0;

    int n_sent = 0;
    int n_dup  = 0;
    int n_del  = 0;

    always #5 clk = ~clk;

    sample_slip_injector u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sample_slip_injector_checker u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    // Offer one beat, optionally after a short idle burst, and return at the
    // edge where it was taken. Valid stays high so back-to-back beats need no
    // second assignment in the same step.
    task automatic send_beat(input logic [ssi_pkg::SAMPLE_W-1:0] smp,
                             input logic [ssi_pkg::EVENT_W-1:0]  ev,
                             input logic [ssi_pkg::LEN_W-1:0]    len);
        if (tx_jitter && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tdata  <= {2'b00, len, smp};
        s_tuser  <= ev;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_sent++;
        if (ev == ssi_pkg::EV_DUP) n_dup++;
        if (ev == ssi_pkg::EV_DEL) n_del++;
    endtask

    // Random beat: mostly plain and short slips, now and then a long one or
    // a degenerate event (zero length, spare code).
    task automatic random_beat();
        int                          r;
        logic [ssi_pkg::LEN_W-1:0]   len;
        logic [ssi_pkg::EVENT_W-1:0] ev;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            ev  = ssi_pkg::EV_NONE;
            len = ssi_pkg::LEN_W'($urandom_range(0, 63));
        end else if (r < 72) begin
            ev = ssi_pkg::EV_DUP;
            case ($urandom_range(0, 19))
                0:       len = 6'd0;
                1, 2:    len = ssi_pkg::LEN_W'($urandom_range(9, 63));
                default: len = ssi_pkg::LEN_W'($urandom_range(1, 8));
            endcase
        end else if (r < 92) begin
            ev = ssi_pkg::EV_DEL;
            case ($urandom_range(0, 29))
                0:       len = 6'd0;
                1:       len = ssi_pkg::LEN_W'($urandom_range(20, 63));
                2, 3:    len = ssi_pkg::LEN_W'($urandom_range(5, 19));
                default: len = ssi_pkg::LEN_W'($urandom_range(1, 4));
            endcase
        end else begin
            ev  = EV_SPARE;
            len = ssi_pkg::LEN_W'($urandom_range(0, 63));
        end
        send_beat($urandom(), ev, len);
    endtask

    // Stop offering and wait for every predicted output beat to come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Receiver: random ready bursts, plus one long hold-off on request.
    initial begin : receiver
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any accepted beat on either side restarts the count.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ssi_pkg::EV_NONE;
        rst_n    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        send_beat(32'h0000_0000, ssi_pkg::EV_NONE, 6'd0);   // all-zero sample
        send_beat(32'hFFFF_FFFF, ssi_pkg::EV_NONE, 6'd63);  // all-ones, length ignored
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd63);      // short history: dropped
        send_beat($urandom(), EV_SPARE, 6'd5);              // spare code acts as none
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd0);       // zero length dup ignored
        send_beat($urandom(), ssi_pkg::EV_DEL, 6'd0);       // zero length delete ignored
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd1);       // shortest replay
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd8);
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd17);
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd35);      // history saturates at full depth
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd63);      // longest replay, 64 output beats
        send_beat($urandom(), ssi_pkg::EV_DEL, 6'd1);       // drops only itself
        send_beat($urandom(), ssi_pkg::EV_NONE, 6'd0);
        send_beat($urandom(), ssi_pkg::EV_DEL, 6'd4);       // drops this and the next three
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd2);       // event inside delete run: dropped
        send_beat($urandom(), ssi_pkg::EV_DEL, 6'd5);       // delete inside run: dropped
        send_beat($urandom(), EV_SPARE, 6'd9);              // no event inside run: not counted
        send_beat($urandom(), ssi_pkg::EV_NONE, 6'd0);      // run is over, emitted
        send_beat($urandom(), ssi_pkg::EV_DEL, 6'd2);
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd0);       // zero length inside run
        send_beat($urandom(), ssi_pkg::EV_DUP, 6'd63);      // full replay right after a delete
        send_beat($urandom(), ssi_pkg::EV_NONE, 6'd42);

        // --- random, both sides idling ---
        repeat (60) random_beat();

        // long receiver stall while the sender keeps pushing duplicates
        hold_req = 1'b1;
        tx_jitter = 1'b0;
        repeat (12)
            send_beat($urandom(), ssi_pkg::EV_DUP, ssi_pkg::LEN_W'($urandom_range(2, 6)));
        tx_jitter = 1'b1;

        // sender pause until everything predicted has come out
        drain();

        repeat (60) random_beat();

        // tail: no idling on either side
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        repeat (20) random_beat();

        drain();
        repeat (10) @(posedge clk);

        $display("covered %0d input beats (%0d duplicate, %0d delete events), %0d output beats",
                 n_sent, n_dup, n_del, checked);
        $display("includes a %0d-cycle output hold-off and a full drain pause", HOLD_CYCLES);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ssi_pkg.sv
rtl/ssi_queue.sv
rtl/ssi_front.sv
rtl/ssi_back.sv
rtl/sample_slip_injector.sv
tb/sample_slip_injector_checker.sv
tb/tb_sample_slip_injector.sv
